// ----- rtl/sfgr_pkg.sv -----
// Package for the sequenced feed gap recovery block: beat types, kind codes,
// queue depths and the back-end sequencer states. No dependencies.
`timescale 1ns / 1ps
package sfgr_pkg;

	localparam int SEQ_W       = 32;
	localparam int MAX_RESULTS = 64;
	localparam int MID_DEPTH   = 2;
	localparam int OUT_DEPTH   = 4;

	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	typedef struct packed {
		logic             from_snapshot;
		logic [SEQ_W-1:0] seq_num;
		logic [1:0]       kind;
		logic [3:0]       update_code;
		logic [63:0]      order_ref;
		logic [63:0]      payload;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  out_code;
		logic [63:0] out_order_ref;
		logic [63:0] out_payload;
		logic        recovered;
		logic        last;
	} out_item_t;

	// Classified beat handed from the front end to the back end.
	typedef struct packed {
		in_item_t item;
		logic     snap_in_range;
	} fe_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  code;
		logic [63:0] order_ref;
		logic [63:0] payload;
	} snap_ent_t;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [1:0]       kind;
		logic [3:0]       code;
		logic [63:0]      order_ref;
		logic [63:0]      payload;
	} inc_ent_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INC_SCAN,
		ST_INC_STORE,
		ST_SNAP_SCAN,
		ST_SNAP_K0,
		ST_SNAP_KE,
		ST_INC_CHECK,
		ST_INC_PERM,
		ST_EMIT_SNAP,
		ST_EMIT_INC,
		ST_FLUSH
	} state_t;

	function automatic logic is_marker(input logic [1:0] k);
		return (k == KIND_START) || (k == KIND_END);
	endfunction

endpackage

// ----- rtl/sfgr_fifo.sv -----
// Small synchronous queue of WIDTH-bit beats, used between the block's parts
// and at the result side. No dependencies.
`timescale 1ns / 1ps
module sfgr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end
endmodule

// ----- rtl/sfgr_front.sv -----
// Front end: input register stage that takes beats and classifies them.
// Depends on sfgr_pkg.
`timescale 1ns / 1ps
module sfgr_front #(
	parameter int SNAP_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sfgr_pkg::in_item_t in_item,
	output logic              full,
	output logic              q_push,
	output sfgr_pkg::fe_item_t q_item,
	input  logic              q_full
);
	import sfgr_pkg::*;

	logic     valid_q;
	fe_item_t item_q;
	logic     take;

	assign full   = valid_q && q_full;
	assign take   = push && !full;
	assign q_push = valid_q;
	assign q_item = item_q;

	always_ff @(posedge clk) begin
		if (take) begin
			item_q.item          <= in_item;
			item_q.snap_in_range <= (in_item.seq_num < SEQ_W'(SNAP_DEPTH));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (take) valid_q <= 1'b1;
		else if (!q_full) valid_q <= 1'b0;
	end
endmodule

// ----- rtl/sfgr_back.sv -----
// Back end: sequence tracking, recovery stores and the check/emit sequencer.
// Depends on sfgr_pkg.
`timescale 1ns / 1ps
module sfgr_back #(
	parameter int SNAP_DEPTH = 32,
	parameter int INC_DEPTH  = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [sfgr_pkg::SEQ_W-1:0] cfg_wdata,
	input  logic                     q_empty,
	output logic                     q_pop,
	input  sfgr_pkg::fe_item_t       q_item,
	input  logic                     o_full,
	output logic                     o_push,
	output sfgr_pkg::out_item_t      o_item
);
	import sfgr_pkg::*;

	localparam int SIW  = $clog2(SNAP_DEPTH);
	localparam int IIW  = $clog2(INC_DEPTH);
	localparam int SCW  = $clog2(SNAP_DEPTH + 1);
	localparam int ICW  = $clog2(INC_DEPTH + 1);
	localparam int MAXD = (SNAP_DEPTH > INC_DEPTH) ? SNAP_DEPTH : INC_DEPTH;
	localparam int CW   = $clog2(MAXD + 1);
	localparam int NW   = $clog2(MAX_RESULTS + 1);

	state_t state_q, state_d;
	logic [1:0]    ph_q;
	logic [CW-1:0] cnt_q, rd_idx_s1;
	logic          rd_vld_s1;

	fe_item_t         it_q;
	logic             rec_q;
	logic [SEQ_W-1:0] ne_q, nx_q;

	logic [SNAP_DEPTH-1:0] snap_vld_q;
	logic [INC_DEPTH-1:0]  inc_vld_q;
	snap_ent_t snap_mem [SNAP_DEPTH];
	inc_ent_t  inc_mem  [INC_DEPTH];
	logic [IIW-1:0] perm_mem [INC_DEPTH];
	snap_ent_t snap_rd_q;
	inc_ent_t  inc_rd_q;
	logic [IIW-1:0] perm_rd_q;

	logic             match_v_q, free_v_q, low_v_q;
	logic [IIW-1:0]   match_idx_q, free_idx_q, low_idx_q;
	logic [SEQ_W-1:0] low_seq_q, max_q;
	logic [SCW-1:0]   scnt_q;
	logic             gap_q, hole_q;
	logic [ICW-1:0]   k_q;

	logic      hold_v_q;
	out_item_t hold_q;
	logic [NW-1:0] n_q;

	// decode
	logic          is_scan, scan_done, d_drop, d_live, inc_ok;
	logic [CW-1:0] scan_len;
	logic [SIW-1:0] sidx, s_raddr, sslot;
	logic [IIW-1:0] iidx, i_raddr, inc_slot;
	logic          s_v, i_v, inc_do_wr, ge_nx;
	logic [SEQ_W-1:0] off;
	logic          em_use, em_take, em_stall;
	snap_ent_t     em_src;

	// controls
	logic snap_clr, inc_clr, finish;

	assign is_scan = (state_q == ST_INC_SCAN) || (state_q == ST_SNAP_SCAN) ||
	                 (state_q == ST_INC_CHECK) || (state_q == ST_INC_PERM);
	assign scan_len  = (state_q == ST_SNAP_SCAN) ? CW'(SNAP_DEPTH) : CW'(INC_DEPTH);
	assign scan_done = is_scan && (cnt_q == scan_len) && !rd_vld_s1;
	assign sidx  = rd_idx_s1[SIW-1:0];
	assign iidx  = rd_idx_s1[IIW-1:0];
	assign s_v   = snap_vld_q[sidx];
	assign i_v   = inc_vld_q[iidx];
	assign ge_nx = inc_rd_q.seq >= nx_q;
	assign off   = inc_rd_q.seq - nx_q;
	assign sslot = it_q.item.seq_num[SIW-1:0];

	assign d_drop = it_q.item.from_snapshot && !rec_q;
	assign d_live = !rec_q && !it_q.item.from_snapshot && (it_q.item.seq_num == ne_q);
	assign inc_ok = (k_q == '0) || ((max_q - nx_q) == (SEQ_W'(k_q) - 1'b1));

	assign inc_do_wr = match_v_q || free_v_q || (it_q.item.seq_num > low_seq_q);
	assign inc_slot  = match_v_q ? match_idx_q : (free_v_q ? free_idx_q : low_idx_q);

	always_comb begin
		em_src = snap_rd_q;
		if (state_q == ST_EMIT_INC) begin
			em_src.kind      = inc_rd_q.kind;
			em_src.code      = inc_rd_q.code;
			em_src.order_ref = inc_rd_q.order_ref;
			em_src.payload   = inc_rd_q.payload;
		end
	end
	assign em_use   = ((state_q == ST_EMIT_SNAP) && (ph_q == 2'd1)) ||
	                  ((state_q == ST_EMIT_INC) && (ph_q == 2'd2));
	assign em_take  = em_use && !is_marker(em_src.kind) && (n_q < NW'(MAX_RESULTS));
	assign em_stall = em_take && hold_v_q && o_full;

	assign s_raddr = (state_q == ST_SNAP_K0) ? '0 :
	                 (state_q == ST_SNAP_KE) ? SIW'(scnt_q - 1'b1) : cnt_q[SIW-1:0];
	assign i_raddr = (state_q == ST_EMIT_INC) ? perm_rd_q : cnt_q[IIW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (!q_empty) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				if (d_drop) state_d = ST_IDLE;
				else if (d_live) begin
					if (!o_full) state_d = ST_IDLE;
				end else if (it_q.item.from_snapshot) state_d = ST_SNAP_SCAN;
				else state_d = ST_INC_SCAN;
			end
			ST_INC_SCAN:  if (scan_done) state_d = ST_INC_STORE;
			ST_INC_STORE: state_d = ST_SNAP_SCAN;
			ST_SNAP_SCAN: if (scan_done) state_d = (scnt_q == '0) ? ST_IDLE : ST_SNAP_K0;
			ST_SNAP_K0: begin
				if (ph_q == 2'd1)
					state_d = (snap_rd_q.kind != KIND_START || hole_q) ? ST_IDLE : ST_SNAP_KE;
			end
			ST_SNAP_KE: begin
				if (ph_q == 2'd1)
					state_d = (snap_rd_q.kind != KIND_END) ? ST_IDLE : ST_INC_CHECK;
			end
			ST_INC_CHECK: if (scan_done) state_d = inc_ok ? ST_INC_PERM : ST_IDLE;
			ST_INC_PERM:  if (scan_done) state_d = ST_EMIT_SNAP;
			ST_EMIT_SNAP: begin
				if (ph_q == 2'd1 && !em_stall && (SCW'(cnt_q) == scnt_q - 1'b1))
					state_d = (k_q == '0) ? ST_FLUSH : ST_EMIT_INC;
			end
			ST_EMIT_INC: begin
				if (ph_q == 2'd2 && !em_stall && (ICW'(cnt_q) == k_q - 1'b1))
					state_d = ST_FLUSH;
			end
			ST_FLUSH: if (!hold_v_q || !o_full) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop    = 1'b0;
		o_push   = 1'b0;
		o_item   = hold_q;
		snap_clr = 1'b0;
		inc_clr  = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			ST_IDLE: q_pop = !q_empty;
			ST_DISPATCH: begin
				if (d_live) begin
					o_push = !o_full;
					o_item = '{out_code: it_q.item.update_code,
					           out_order_ref: it_q.item.order_ref,
					           out_payload: it_q.item.payload,
					           recovered: 1'b0, last: 1'b1};
				end else if (!d_drop) begin
					inc_clr  = !rec_q;
					snap_clr = it_q.item.from_snapshot &&
					           (!rec_q || !it_q.snap_in_range || snap_vld_q[sslot]);
				end
			end
			ST_SNAP_SCAN: snap_clr = scan_done && (scnt_q == '0) && hole_q;
			ST_SNAP_K0: snap_clr = (ph_q == 2'd1) && (snap_rd_q.kind != KIND_START || hole_q);
			ST_INC_CHECK: snap_clr = scan_done && !inc_ok;
			ST_EMIT_SNAP, ST_EMIT_INC: begin
				o_push = em_take && hold_v_q && !o_full;
			end
			ST_FLUSH: begin
				o_push = hold_v_q && !o_full;
				o_item.last = 1'b1;
				if (!hold_v_q || !o_full) begin
					finish   = 1'b1;
					snap_clr = 1'b1;
					inc_clr  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (state_q == ST_DISPATCH && !d_live && !d_drop && it_q.item.from_snapshot &&
		    it_q.snap_in_range)
			snap_mem[sslot] <= '{kind: it_q.item.kind, code: it_q.item.update_code,
			                     order_ref: it_q.item.order_ref, payload: it_q.item.payload};
		snap_rd_q <= snap_mem[s_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_INC_STORE && inc_do_wr)
			inc_mem[inc_slot] <= '{seq: it_q.item.seq_num, kind: it_q.item.kind,
			                      code: it_q.item.update_code,
			                      order_ref: it_q.item.order_ref, payload: it_q.item.payload};
		inc_rd_q <= inc_mem[i_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_INC_PERM && rd_vld_s1 && i_v && ge_nx)
			perm_mem[off[IIW-1:0]] <= iidx;
		perm_rd_q <= perm_mem[cnt_q[IIW-1:0]];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) it_q <= q_item;
		if (state_q == ST_SNAP_KE && ph_q == 2'd1)
			nx_q <= snap_rd_q.order_ref[SEQ_W-1:0] + 1'b1;
		if (em_take && !em_stall)
			hold_q <= '{out_code: em_src.code, out_order_ref: em_src.order_ref,
			            out_payload: em_src.payload, recovered: 1'b1, last: 1'b0};
	end

	// control and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ph_q       <= '0;
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_idx_s1  <= '0;
			rec_q      <= 1'b0;
			ne_q       <= SEQ_W'(1);
			snap_vld_q <= '0;
			inc_vld_q  <= '0;
			match_v_q  <= 1'b0;
			free_v_q   <= 1'b0;
			low_v_q    <= 1'b0;
			match_idx_q <= '0;
			free_idx_q <= '0;
			low_idx_q  <= '0;
			low_seq_q  <= '0;
			max_q      <= '0;
			scnt_q     <= '0;
			gap_q      <= 1'b0;
			hole_q     <= 1'b0;
			k_q        <= '0;
			hold_v_q   <= 1'b0;
			n_q        <= '0;
		end else begin
			state_q <= state_d;

			// sweep counter and registered read pipeline
			if (state_d != state_q) begin
				cnt_q     <= '0;
				ph_q      <= '0;
				rd_vld_s1 <= 1'b0;
			end else if (is_scan) begin
				if (cnt_q != scan_len) cnt_q <= cnt_q + 1'b1;
				rd_vld_s1 <= (cnt_q != scan_len);
				rd_idx_s1 <= cnt_q;
			end else if (state_q == ST_SNAP_K0 || state_q == ST_SNAP_KE) begin
				ph_q <= 2'd1;
			end else if (state_q == ST_EMIT_SNAP) begin
				if (ph_q == 2'd0) ph_q <= 2'd1;
				else if (!em_stall) begin
					ph_q  <= 2'd0;
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (state_q == ST_EMIT_INC) begin
				if (ph_q != 2'd2) ph_q <= ph_q + 1'b1;
				else if (!em_stall) begin
					ph_q  <= 2'd0;
					cnt_q <= cnt_q + 1'b1;
				end
			end

			// enter recovery, advance live sequence
			if (state_q == ST_DISPATCH) begin
				if (d_live && !o_full) ne_q <= ne_q + 1'b1;
				if (!d_live && !d_drop) rec_q <= 1'b1;
			end
			if (finish) begin
				rec_q <= 1'b0;
				ne_q  <= nx_q + SEQ_W'(k_q);
			end
			if (cfg_we) ne_q <= cfg_wdata;

			// valid bits
			if (snap_clr) snap_vld_q <= '0;
			if (state_q == ST_DISPATCH && !d_live && !d_drop && it_q.item.from_snapshot &&
			    it_q.snap_in_range) begin
				if (snap_clr) snap_vld_q <= SNAP_DEPTH'(1) << sslot;
				else snap_vld_q[sslot] <= 1'b1;
			end
			if (inc_clr) inc_vld_q <= '0;
			if (state_q == ST_INC_STORE && inc_do_wr) inc_vld_q[inc_slot] <= 1'b1;

			// accumulator reset on entry to a sweep or to the replay, else accumulate
			if (state_d != state_q) begin
				if (state_d == ST_INC_SCAN) begin
					match_v_q <= 1'b0;
					free_v_q  <= 1'b0;
					low_v_q   <= 1'b0;
				end
				if (state_d == ST_SNAP_SCAN) begin
					scnt_q <= '0;
					gap_q  <= 1'b0;
					hole_q <= 1'b0;
				end
				if (state_d == ST_INC_CHECK) k_q <= '0;
				if (state_d == ST_EMIT_SNAP) begin
					hold_v_q <= 1'b0;
					n_q      <= '0;
				end
			end else if (rd_vld_s1) begin
				unique case (state_q)
					ST_INC_SCAN: begin
						if (!i_v) begin
							if (!free_v_q) begin
								free_v_q   <= 1'b1;
								free_idx_q <= iidx;
							end
						end else begin
							if (inc_rd_q.seq == it_q.item.seq_num) begin
								match_v_q   <= 1'b1;
								match_idx_q <= iidx;
							end
							if (!low_v_q || inc_rd_q.seq < low_seq_q) begin
								low_v_q   <= 1'b1;
								low_seq_q <= inc_rd_q.seq;
								low_idx_q <= iidx;
							end
						end
					end
					ST_SNAP_SCAN: begin
						if (s_v && !gap_q) scnt_q <= scnt_q + 1'b1;
						if (!s_v) gap_q <= 1'b1;
						if (s_v && gap_q) hole_q <= 1'b1;
					end
					ST_INC_CHECK: begin
						if (i_v && ge_nx) begin
							k_q <= k_q + 1'b1;
							if (k_q == '0 || inc_rd_q.seq > max_q) max_q <= inc_rd_q.seq;
						end
					end
					default: ;
				endcase
			end

			// hold the newest recovered beat so the final one can carry last
			if (em_take && !em_stall) begin
				hold_v_q <= 1'b1;
				n_q      <= n_q + 1'b1;
			end
			if (state_q == ST_FLUSH && o_push) hold_v_q <= 1'b0;
		end
	end
endmodule

// ----- rtl/sequenced_feed_gap_recovery.sv -----
// Top level of the sequenced feed gap recovery block.
// Depends on sfgr_pkg, sfgr_front, sfgr_fifo and sfgr_back.
`timescale 1ns / 1ps
// Feed sequencer with snapshot gap recovery. Both sides look like a queue:
// push a decoded message while full is low, pop results while empty is low.
// An in-order incremental beat is forwarded as one live result (recovered=0,
// last=1) once the result queue has room; the back-end sequencer takes one
// beat at a time, and the front register and a two-entry queue keep taking
// beats meanwhile. Snapshot beats outside recovery are dropped. A sequence gap
// starts recovery: the incremental store is cleared (the snapshot store is
// already empty) and each later beat is stored (snapshot by sequence slot,
// incremental fully associative). After every stored beat the sequencer
// sweeps its stores one entry per cycle; when recovery completes, the
// incrementals are put in order and the buffered updates are replayed
// (markers left out, recovered=1, last on the final beat, at most 64 beats),
// and a full result queue can hold the replay. The back end owns a single
// read port per store, so it sweeps them entry by entry. The cfg write loads
// the expected incremental sequence number (reset value 1); write it only
// while idle.
module sequenced_feed_gap_recovery #(
	parameter int SNAP_DEPTH = 32,
	parameter int INC_DEPTH  = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  sfgr_pkg::in_item_t         in_item,
	output logic                       empty,
	input  logic                       pop,
	output sfgr_pkg::out_item_t        out_item,
	input  logic                       cfg_we,
	input  logic [sfgr_pkg::SEQ_W-1:0] cfg_wdata
);
	import sfgr_pkg::*;

	localparam int FE_W  = $bits(fe_item_t);
	localparam int OUT_W = $bits(out_item_t);

	logic      fe_push, mid_full, mid_empty, mid_pop;
	fe_item_t  fe_item, mid_item;
	logic      o_push, o_full;
	out_item_t o_item;

	// Front: register and classify each accepted beat.
	sfgr_front #(.SNAP_DEPTH(SNAP_DEPTH)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.in_item (in_item),
		.full    (full),
		.q_push  (fe_push),
		.q_item  (fe_item),
		.q_full  (mid_full)
	);

	// Decoupling queue between front and back.
	sfgr_fifo #(.WIDTH(FE_W), .DEPTH(MID_DEPTH)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_push),
		.wdata  (fe_item),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_item),
		.empty  (mid_empty)
	);

	// Back: sequence tracking, stores, recovery check and replay.
	sfgr_back #(.SNAP_DEPTH(SNAP_DEPTH), .INC_DEPTH(INC_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_empty   (mid_empty),
		.q_pop     (mid_pop),
		.q_item    (mid_item),
		.o_full    (o_full),
		.o_push    (o_push),
		.o_item    (o_item)
	);

	// Result queue: the back end keeps working while a beat waits for pop.
	sfgr_fifo #(.WIDTH(OUT_W), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (o_push),
		.wdata  (o_item),
		.full   (o_full),
		.pop    (pop),
		.rdata  (out_item),
		.empty  (empty)
	);
endmodule

// ----- rtl/sfgr_checker.sv -----
// Port-level checks for the sequenced feed gap recovery block, bound to the
// top level. Depends on sfgr_pkg.
`timescale 1ns / 1ps
module sfgr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                empty,
	input logic                pop,
	input sfgr_pkg::out_item_t out_item
);
	// A live forward is always a single beat.
	a_live_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_item.recovered) |-> out_item.last)
		else $error("live beat without last");

	// A replay burst is never broken by a live beat.
	a_burst_whole: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && out_item.recovered && !out_item.last) |=>
		(empty || out_item.recovered))
		else $error("replay burst interrupted");

	// Hold a waiting beat until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_item)))
		else $error("waiting result changed");
endmodule

bind sequenced_feed_gap_recovery sfgr_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.out_item (out_item)
);
